// ===== rtl/radial_vignette_alpha_assert.svh =====
// Assertion macros for the radial vignette alpha RTL.
`ifndef RADIAL_VIGNETTE_ALPHA_ASSERT_SVH
`define RADIAL_VIGNETTE_ALPHA_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define RVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RVA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/rva_pkg.sv =====
// Package with shared types, widths and register indexes of the vignette block.
`timescale 1ns / 1ps
`default_nettype none
package rva_pkg;
  localparam int unsigned MASK_SIZE_DEF = 512;
  localparam int unsigned COORD_W = 9;
  localparam int unsigned RAD_W   = 13;
  localparam int unsigned OFS_W   = 13;
  localparam int unsigned V_W     = 32;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SREM_W  = 18;
  localparam int unsigned T_W     = 16;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INNER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 1'b1;

  localparam logic [RAD_W-1:0] INNER_RESET = 13'd410;
  localparam logic [RAD_W-1:0] OUTER_RESET = 13'd819;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_FULL,
    MODE_RAMP
  } mode_e;

  typedef struct packed {
    logic  valid;
    mode_e mode;
  } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/radial_vignette_alpha.sv =====
// Top level of the radial vignette alpha block.
`timescale 1ns / 1ps
`default_nettype none
// Radial vignette alpha: for each requested mask pixel (pixel_x_i, pixel_y_i) the block
// gives the overlay opacity alpha_o, 0 inside the inner radius, 255 at or beyond the
// outer radius, and a smoothstep-shaped ramp in between. Distances are in sixteenths
// of a pixel. The datapath is a 38-stage pipeline: offset, square-sum, a chain of 16
// square root cells (one root bit each), a compare stage, a chain of 16 divider cells
// (one quotient bit each) and three multiplier stages for smoothstep and scaling.
// One request is taken every clock unless back-pressure from the output fills the pipe;
// each result passes through every stage in order and leaves from the output register.
// Each stage advances on its own when the stage after it is empty or moving, so gaps
// in the stream are squeezed out and requests keep entering while a result waits.
// The radius registers may only be written while the pipeline holds no request.
`include "radial_vignette_alpha_assert.svh"
module radial_vignette_alpha
  import rva_pkg::*;
#(
  parameter int unsigned MASK_SIZE = MASK_SIZE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [RAD_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [COORD_W-1:0]   pixel_x_i,
  input  wire logic [COORD_W-1:0]   pixel_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ALPHA_W-1:0]        alpha_o
);
  localparam int unsigned NSQ = DIST_W;
  localparam int unsigned NDV = T_W;
  localparam int unsigned ST_SQ = 2;
  localparam int unsigned ST_C  = ST_SQ + NSQ;
  localparam int unsigned ST_DV = ST_C + 1;
  localparam int unsigned ST_SM = ST_DV + NDV;
  localparam int unsigned NST   = ST_SM + 3;

  // Radius registers.
  logic [RAD_W-1:0] inner_q, inner_d;
  logic [RAD_W-1:0] outer_q, outer_d;
  logic [RAD_W-1:0] span;

  always_comb begin
    inner_d = inner_q;
    outer_d = outer_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INNER: inner_d = cfg_wdata_i;
        REG_OUTER: outer_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_RESET;
      outer_q <= OUTER_RESET;
    end else begin
      inner_q <= inner_d;
      outer_q <= outer_d;
    end
  end

  assign span = outer_q - inner_q;

  // Per-stage valid bits and the advance chain, walked from the output backwards.
  logic [NST-1:0] vld;
  logic [NST:0]   en;

  assign en[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_ready_o = en[0];

  // Stage A: absolute half-pixel offsets from the mask center.
  ctl_t a_ctl_q;
  logic [OFS_W-1:0] ax_q, ay_q;
  logic signed [OFS_W:0] dx, dy;

  assign dx = $signed({{(OFS_W-COORD_W){1'b0}}, pixel_x_i, 1'b0}) - $signed((OFS_W+1)'(MASK_SIZE));
  assign dy = $signed({{(OFS_W-COORD_W){1'b0}}, pixel_y_i, 1'b0}) - $signed((OFS_W+1)'(MASK_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '{valid: 1'b0, mode: MODE_CLEAR};
    end else if (en[0]) begin
      a_ctl_q <= '{valid: in_valid_i, mode: MODE_CLEAR};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax_q <= OFS_W'(dx < 0 ? -dx : dx);
      ay_q <= OFS_W'(dy < 0 ? -dy : dy);
    end
  end

  // Stage B: sum of squares scaled by 64, the radicand of the distance.
  ctl_t b_ctl_q;
  logic [V_W-1:0] v_q;
  logic [2*OFS_W-1:0] ax_sq, ay_sq;
  logic [2*OFS_W:0] sum;

  // The squares are formed at full product width before they are added.
  assign ax_sq = {{OFS_W{1'b0}}, ax_q} * {{OFS_W{1'b0}}, ax_q};
  assign ay_sq = {{OFS_W{1'b0}}, ay_q} * {{OFS_W{1'b0}}, ay_q};
  assign sum   = {1'b0, ax_sq} + {1'b0, ay_sq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctl_q <= '{valid: 1'b0, mode: MODE_CLEAR};
    end else if (en[1]) begin
      b_ctl_q <= a_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      v_q <= V_W'({sum, 6'b000000});
    end
  end

  // Square root chain: each cell settles one bit of the floor root.
  ctl_t              sq_ctl  [NSQ+1];
  logic [SREM_W-1:0] sq_rem  [NSQ+1];
  logic [DIST_W-1:0] sq_root [NSQ+1];
  logic [V_W-1:0]    sq_vsh  [NSQ+1];

  assign sq_ctl[0]  = b_ctl_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_vsh[0]  = v_q;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    rva_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[ST_SQ+i]),
      .ctl_i  (sq_ctl[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .vsh_i  (sq_vsh[i]),
      .ctl_o  (sq_ctl[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .vsh_o  (sq_vsh[i+1])
    );
  end

  // Stage C: classify the distance against the two radii and form the ramp numerator.
  ctl_t c_ctl_q;
  logic [RAD_W-1:0] num_q;
  mode_e c_mode;
  logic [DIST_W-1:0] dist_val;

  assign dist_val = sq_root[NSQ];

  always_comb begin
    if (dist_val <= DIST_W'(inner_q)) begin
      c_mode = MODE_CLEAR;
    end else if (dist_val >= DIST_W'(outer_q)) begin
      c_mode = MODE_FULL;
    end else begin
      c_mode = MODE_RAMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_ctl_q <= '{valid: 1'b0, mode: MODE_CLEAR};
    end else if (en[ST_C]) begin
      c_ctl_q <= '{valid: sq_ctl[NSQ].valid, mode: c_mode};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_C]) begin
      num_q <= RAD_W'(dist_val - DIST_W'(inner_q));
    end
  end

  // Divider chain: each cell settles one bit of the Q0.16 ramp position.
  ctl_t             dv_ctl [NDV+1];
  logic [RAD_W-1:0] dv_rem [NDV+1];
  logic [T_W-1:0]   dv_q   [NDV+1];

  assign dv_ctl[0] = c_ctl_q;
  assign dv_rem[0] = num_q;
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < NDV; i++) begin : g_dv
    rva_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[ST_DV+i]),
      .span_i (span),
      .ctl_i  (dv_ctl[i]),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .ctl_o  (dv_ctl[i+1]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1])
    );
  end

  // Smoothstep and scaling; its last stage is the output register.
  ctl_t [2:0] sm_ctl;

  rva_smooth u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[ST_SM+2:ST_SM]),
    .ctl_i   (dv_ctl[NDV]),
    .t_i     (dv_q[NDV]),
    .ctl_o   (sm_ctl),
    .alpha_o (alpha_o)
  );

  // Valid bits of every stage, in pipeline order.
  always_comb begin
    vld[0] = a_ctl_q.valid;
    vld[1] = b_ctl_q.valid;
    for (int i = 0; i < NSQ; i++) vld[ST_SQ+i] = sq_ctl[i+1].valid;
    vld[ST_C] = c_ctl_q.valid;
    for (int i = 0; i < NDV; i++) vld[ST_DV+i] = dv_ctl[i+1].valid;
    for (int i = 0; i < 3; i++) vld[ST_SM+i] = sm_ctl[i].valid;
  end

  assign out_valid_o = vld[NST-1];

  // The input side may only stall when the whole pipe is backed up by the output.
  `RVA_ASSERT(a_stall_from_out, !in_ready_o |-> (out_valid_o && !out_ready_i),
    "input stalled without output back-pressure")
  // A ramp request always has a numerator below the span.
  `RVA_ASSERT(a_ramp_range, (c_ctl_q.valid && c_ctl_q.mode == MODE_RAMP) |-> (num_q < span),
    "ramp numerator not below span")
  // An accepted request lands in the first stage.
  `RVA_ASSERT(a_accept_lands, (in_valid_i && in_ready_o) |=> a_ctl_q.valid,
    "accepted request lost at entry")
endmodule
`default_nettype wire

// ===== rtl/rva_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rva_sqrt_cell
  import rva_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire ctl_t              ctl_i,
  input  wire logic [SREM_W-1:0] rem_i,
  input  wire logic [DIST_W-1:0] root_i,
  input  wire logic [V_W-1:0]    vsh_i,
  output ctl_t                   ctl_o,
  output logic      [SREM_W-1:0] rem_o,
  output logic      [DIST_W-1:0] root_o,
  output logic      [V_W-1:0]    vsh_o
);
  logic [SREM_W+1:0] pre;
  logic [SREM_W+1:0] trial;
  logic              take;

  assign pre   = {rem_i, vsh_i[V_W-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign take  = (pre >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '{valid: 1'b0, mode: MODE_CLEAR};
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= take ? SREM_W'(pre - trial) : SREM_W'(pre);
      root_o <= {root_i[DIST_W-2:0], take};
      vsh_o  <= {vsh_i[V_W-3:0], 2'b00};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rva_div_cell.sv =====
// One cell of the restoring divider chain: resolves one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rva_div_cell
  import rva_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [RAD_W-1:0] span_i,
  input  wire ctl_t             ctl_i,
  input  wire logic [RAD_W-1:0] rem_i,
  input  wire logic [T_W-1:0]   q_i,
  output ctl_t                  ctl_o,
  output logic      [RAD_W-1:0] rem_o,
  output logic      [T_W-1:0]   q_o
);
  logic [RAD_W:0] sh;
  logic           take;

  assign sh   = {rem_i, 1'b0};
  assign take = (sh >= {1'b0, span_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '{valid: 1'b0, mode: MODE_CLEAR};
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? RAD_W'(sh - {1'b0, span_i}) : RAD_W'(sh);
      q_o   <= {q_i[T_W-2:0], take};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rva_smooth.sv =====
// Smoothstep shaping and 8-bit scaling in three multiplier stages.
`timescale 1ns / 1ps
`default_nettype none
module rva_smooth
  import rva_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     en_i,
  input  wire ctl_t           ctl_i,
  input  wire logic [T_W-1:0] t_i,
  output ctl_t      [2:0]     ctl_o,
  output logic [ALPHA_W-1:0]  alpha_o
);
  logic [2*T_W-1:0] tt_q;
  logic [T_W+1:0]   k_q;
  logic [T_W-1:0]   s_q;
  logic [2*T_W+T_W+1:0] prod;
  logic [T_W+ALPHA_W-1:0] scaled;
  logic [ALPHA_W-1:0] alpha_d;

  assign prod   = tt_q * k_q;
  assign scaled = s_q * (T_W+ALPHA_W)'(255);

  always_comb begin
    unique case (ctl_o[1].mode)
      MODE_CLEAR: alpha_d = '0;
      MODE_FULL:  alpha_d = '1;
      MODE_RAMP:  alpha_d = scaled[T_W +: ALPHA_W];
      default:    alpha_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '{default: '{valid: 1'b0, mode: MODE_CLEAR}};
    end else begin
      if (en_i[0]) ctl_o[0] <= ctl_i;
      if (en_i[1]) ctl_o[1] <= ctl_o[0];
      if (en_i[2]) ctl_o[2] <= ctl_o[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tt_q <= t_i * t_i;
      k_q  <= (T_W+2)'(3 * 65536) - {1'b0, t_i, 1'b0};
    end
    if (en_i[1]) begin
      s_q <= prod[2*T_W +: T_W];
    end
    if (en_i[2]) begin
      alpha_o <= alpha_d;
    end
  end
endmodule
`default_nettype wire
